// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the envelope generator RTL. Properties are
// clocked on clock; the plain form is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked outside reset
`define LAE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define LAE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LAE_ASSERT(lbl, prop, msg)
`define LAE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/lae_pkg.sv =====
// ----------------------------------------------------------------------------
// lae_pkg
// Widths, codes and controller/datapath interface types of the linear
// ADSR envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lae_pkg;

   // field and storage widths
   localparam int COUNT_BITS  = 21;
   localparam int SAMPLE_BITS = 16;
   localparam int LEN_BITS    = 20;
   localparam int LEVEL_BITS  = 17;
   localparam int ACTION_BITS = 2;
   localparam int STAGE_BITS  = 3;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 20;

   // level ramp arithmetic: 17 x 20 product, one quotient bit per step
   localparam int PROD_BITS  = LEVEL_BITS + LEN_BITS;
   localparam int DIV_STEPS  = LEVEL_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [LEVEL_BITS-1:0] FULL_SCALE = LEVEL_BITS'(65536);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

   // request actions
   localparam logic [ACTION_BITS-1:0] ACT_TICK     = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_NOTE_ON  = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_NOTE_OFF = 2'd2;

   // envelope stages
   localparam logic [STAGE_BITS-1:0] ST_INACTIVE = 3'd0;
   localparam logic [STAGE_BITS-1:0] ST_ATTACK   = 3'd1;
   localparam logic [STAGE_BITS-1:0] ST_DECAY    = 3'd2;
   localparam logic [STAGE_BITS-1:0] ST_SUSTAIN  = 3'd3;
   localparam logic [STAGE_BITS-1:0] ST_RELEASE  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ATTACK        = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECAY         = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELEASE       = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SUSTAIN_LEVEL = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SUSTAIN_ON    = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic note_on;
      logic note_off;
      logic capture;
      logic advance;
      logic mul;
      logic div_step;
      logic level;
      logic load_out;
   } lae_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_last;
   } lae_status_type;

endpackage

`default_nettype wire

// ===== design/lae_ctrl.sv =====
// ----------------------------------------------------------------------------
// lae_ctrl
// Sequencer of the envelope generator: takes requests, steps the datapath
// through advance, multiply, divide, level and scale, and owns rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lae_ctrl
   import lae_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [ACTION_BITS-1:0] req_action,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output lae_cmd_type                 ctrl_cmd,
   input  wire lae_status_type         dp_status
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ADV   = 6'b000010,
      S_MUL   = 6'b000100,
      S_DIV   = 6'b001000,
      S_LEVEL = 6'b010000,
      S_SCALE = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           out_free;

   // handshake
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      ctrl_cmd          = '0;
      ctrl_cmd.note_on  = accept && (req_action == ACT_NOTE_ON);
      ctrl_cmd.note_off = accept && (req_action == ACT_NOTE_OFF);
      ctrl_cmd.capture  = accept && (req_action == ACT_TICK);
      ctrl_cmd.advance  = (state_ff == S_ADV);
      ctrl_cmd.mul      = (state_ff == S_MUL);
      ctrl_cmd.div_step = (state_ff == S_DIV);
      ctrl_cmd.level    = (state_ff == S_LEVEL);
      ctrl_cmd.load_out = (state_ff == S_SCALE) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl_cmd.capture) state_in = S_ADV;
         end
         S_ADV:   state_in = S_MUL;
         S_MUL:   state_in = S_DIV;
         S_DIV: begin
            if (dp_status.div_last) state_in = S_LEVEL;
         end
         S_LEVEL: state_in = S_SCALE;
         S_SCALE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl_cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready)    rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `LAE_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == S_IDLE) && !rsp_valid_ff, "reset did not idle controller")
   `LAE_ASSERT(a_div_length, (state_ff == S_MUL) |-> ##DIV_STEPS (state_ff == S_DIV) ##1 (state_ff == S_LEVEL), "divide ran wrong number of steps")
   `LAE_ASSERT(a_scale_holds, (state_ff == S_SCALE) && rsp_valid_ff && !rsp_ready |=> (state_ff == S_SCALE), "result dropped while output stalled")

endmodule

`default_nettype wire

// ===== design/lae_datapath.sv =====
// ----------------------------------------------------------------------------
// lae_datapath
// Envelope state, configuration registers, ramp multiplier, restoring
// divider, level clamp and sample scaling, driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lae_datapath
   import lae_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lae_cmd_type                   ctrl_cmd,
   output lae_status_type                     dp_status,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata,
   output logic [LEVEL_BITS-1:0]              rsp_level_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic [STAGE_BITS-1:0]              rsp_stage_out
);

   typedef enum logic [1:0] {
      LV_DIRECT,
      LV_ADD,
      LV_SUB,
      LV_QUOT
   } level_mode_type;

   // configuration
   logic [LEN_BITS-1:0]   attack_len_ff, attack_len_in;
   logic [LEN_BITS-1:0]   decay_len_ff, decay_len_in;
   logic [LEN_BITS-1:0]   release_len_ff, release_len_in;
   logic [LEVEL_BITS-1:0] sustain_level_ff, sustain_level_in;
   logic                  sustain_on_ff, sustain_on_in;

   // envelope state
   logic [STAGE_BITS-1:0] stage_ff, stage_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [LEVEL_BITS-1:0] level_now_ff, level_now_in;
   logic [LEVEL_BITS-1:0] level_start_ff, level_start_in;
   logic [COUNT_BITS-1:0] count_inc;

   // ramp operands
   logic [LEN_BITS-1:0]   len_sel;
   logic [LEN_BITS-1:0]   n_clip;
   logic [LEVEL_BITS-1:0] l0_clip;
   logic [LEVEL_BITS-1:0] op_a;
   logic [LEN_BITS-1:0]   op_b;
   logic [LEVEL_BITS-1:0] op_base;
   logic [LEVEL_BITS-1:0] op_direct;
   level_mode_type        op_mode;
   logic [PROD_BITS-1:0]  prod;

   // divider and level registers
   level_mode_type         mode_ff;
   logic [LEVEL_BITS-1:0]  base_ff;
   logic [LEVEL_BITS-1:0]  direct_ff;
   logic [LEN_BITS-1:0]    div_len_ff;
   logic [LEN_BITS-1:0]    rem_ff;
   logic [DIV_STEPS-1:0]   num_lo_ff;
   logic [DIV_STEPS-1:0]   quot_ff;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic [LEN_BITS:0]      rem_wide;
   logic [LEN_BITS:0]      rem_diff;
   logic                   rem_ge;
   logic [LEVEL_BITS:0]    level_raw;
   logic [LEVEL_BITS-1:0]  level_clamp;

   // sample and output
   logic signed [SAMPLE_BITS-1:0]          sample_ff;
   logic signed [SAMPLE_BITS+LEVEL_BITS:0] scaled;
   logic [LEVEL_BITS-1:0]                  level_out_ff;
   logic signed [SAMPLE_BITS-1:0]          sample_out_ff;
   logic [STAGE_BITS-1:0]                  stage_out_ff;

   // register writes
   always_comb begin
      attack_len_in    = attack_len_ff;
      decay_len_in     = decay_len_ff;
      release_len_in   = release_len_ff;
      sustain_level_in = sustain_level_ff;
      sustain_on_in    = sustain_on_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ATTACK:        attack_len_in    = csr_wdata[LEN_BITS-1:0];
            CSR_DECAY:         decay_len_in     = csr_wdata[LEN_BITS-1:0];
            CSR_RELEASE:       release_len_in   = csr_wdata[LEN_BITS-1:0];
            CSR_SUSTAIN_LEVEL: sustain_level_in = csr_wdata[LEVEL_BITS-1:0];
            CSR_SUSTAIN_ON:    sustain_on_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage counter, stage moves, note events and level update
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   always_comb begin
      stage_in       = stage_ff;
      count_in       = count_ff;
      level_now_in   = level_now_ff;
      level_start_in = level_start_ff;
      if (ctrl_cmd.note_on) begin
         level_start_in = level_now_ff;
         stage_in       = ST_ATTACK;
         count_in       = '0;
      end else if (ctrl_cmd.note_off) begin
         if (stage_ff != ST_INACTIVE) begin
            stage_in = ST_RELEASE;
            count_in = '0;
         end
      end else if (ctrl_cmd.advance) begin
         count_in = count_inc;
         if (stage_ff == ST_ATTACK && count_inc >= COUNT_BITS'(attack_len_ff)) begin
            stage_in = ST_DECAY;
            count_in = '0;
         end else if (stage_ff == ST_DECAY && count_inc >= COUNT_BITS'(decay_len_ff)) begin
            stage_in = sustain_on_ff ? ST_SUSTAIN : ST_RELEASE;
            count_in = '0;
         end else if (stage_ff == ST_RELEASE &&
                      count_inc >= COUNT_BITS'(release_len_ff)) begin
            stage_in = ST_INACTIVE;
            count_in = '0;
         end
      end else if (ctrl_cmd.level) begin
         level_now_in = level_clamp;
      end
   end

   // stage length and clipped count
   always_comb begin
      case (stage_ff)
         ST_ATTACK:  len_sel = attack_len_ff;
         ST_DECAY:   len_sel = decay_len_ff;
         ST_RELEASE: len_sel = release_len_ff;
         default:    len_sel = '0;
      endcase
   end

   assign n_clip  = (count_ff > COUNT_BITS'(len_sel)) ? len_sel : count_ff[LEN_BITS-1:0];
   assign l0_clip = (level_start_ff > FULL_SCALE) ? FULL_SCALE : level_start_ff;

   // ramp operands per stage
   always_comb begin
      op_mode   = LV_DIRECT;
      op_a      = '0;
      op_b      = '0;
      op_base   = '0;
      op_direct = '0;
      case (stage_ff)
         ST_ATTACK: begin
            if (len_sel == '0) begin
               op_direct = FULL_SCALE;
            end else begin
               op_mode = LV_ADD;
               op_base = l0_clip;
               op_a    = FULL_SCALE - l0_clip;
               op_b    = n_clip;
            end
         end
         ST_DECAY: begin
            if (len_sel == '0) begin
               op_direct = sustain_level_ff;
            end else if (sustain_level_ff >= FULL_SCALE) begin
               op_direct = FULL_SCALE;
            end else begin
               op_mode = LV_SUB;
               op_a    = FULL_SCALE - sustain_level_ff;
               op_b    = n_clip;
            end
         end
         ST_SUSTAIN: op_direct = sustain_level_ff;
         ST_RELEASE: begin
            if (len_sel != '0) begin
               op_mode = LV_QUOT;
               op_a    = sustain_level_ff;
               op_b    = len_sel - n_clip;
            end
         end
         default: op_direct = '0;
      endcase
   end

   assign prod = op_a * op_b;

   // restoring divide step, quotient known to fit in DIV_STEPS bits
   assign rem_wide = {rem_ff, num_lo_ff[DIV_STEPS-1]};
   assign rem_ge   = (rem_wide >= {1'b0, div_len_ff});
   assign rem_diff = rem_wide - {1'b0, div_len_ff};

   assign div_cnt_in = ctrl_cmd.mul ? '0 :
                       ctrl_cmd.div_step ? div_cnt_ff + 1'b1 : div_cnt_ff;
   assign dp_status.div_last = ctrl_cmd.div_step &&
                               (div_cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1));

   // level from quotient or direct value, clamped to full scale
   always_comb begin
      case (mode_ff)
         LV_ADD:  level_raw = {1'b0, base_ff} + {1'b0, quot_ff};
         LV_SUB:  level_raw = {1'b0, FULL_SCALE} - {1'b0, quot_ff};
         LV_QUOT: level_raw = {1'b0, quot_ff};
         default: level_raw = {1'b0, direct_ff};
      endcase
   end

   assign level_clamp = (level_raw > {1'b0, FULL_SCALE}) ? FULL_SCALE :
                        level_raw[LEVEL_BITS-1:0];

   // sample scaling, arithmetic shift gives the floor
   assign scaled = sample_ff * $signed({1'b0, level_now_ff});

   // control and envelope state
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff    <= '0;
         decay_len_ff     <= '0;
         release_len_ff   <= '0;
         sustain_level_ff <= FULL_SCALE;
         sustain_on_ff    <= 1'b1;
         stage_ff         <= ST_INACTIVE;
         count_ff         <= '0;
         level_now_ff     <= '0;
         level_start_ff   <= '0;
         div_cnt_ff       <= '0;
      end else begin
         attack_len_ff    <= attack_len_in;
         decay_len_ff     <= decay_len_in;
         release_len_ff   <= release_len_in;
         sustain_level_ff <= sustain_level_in;
         sustain_on_ff    <= sustain_on_in;
         stage_ff         <= stage_in;
         count_ff         <= count_in;
         level_now_ff     <= level_now_in;
         level_start_ff   <= level_start_in;
         div_cnt_ff       <= div_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) sample_ff <= req_sample_in;
      if (ctrl_cmd.mul) begin
         mode_ff    <= op_mode;
         base_ff    <= op_base;
         direct_ff  <= op_direct;
         div_len_ff <= len_sel;
         rem_ff     <= prod[PROD_BITS-1:DIV_STEPS];
         num_lo_ff  <= prod[DIV_STEPS-1:0];
         quot_ff    <= '0;
      end else if (ctrl_cmd.div_step) begin
         rem_ff    <= rem_ge ? rem_diff[LEN_BITS-1:0] : rem_wide[LEN_BITS-1:0];
         num_lo_ff <= {num_lo_ff[DIV_STEPS-2:0], 1'b0};
         quot_ff   <= {quot_ff[DIV_STEPS-2:0], rem_ge};
      end
      if (ctrl_cmd.load_out) begin
         level_out_ff  <= level_now_ff;
         sample_out_ff <= scaled[SAMPLE_BITS+15:16];
         stage_out_ff  <= stage_ff;
      end
   end

   assign rsp_level_out  = level_out_ff;
   assign rsp_sample_out = sample_out_ff;
   assign rsp_stage_out  = stage_out_ff;

   // checks
   `LAE_ASSERT(a_level_range, level_now_ff <= FULL_SCALE, "stored level above full scale")
   `LAE_ASSERT(a_stage_code, stage_ff <= ST_RELEASE, "stage register holds unused code")
   `LAE_ASSERT(a_rem_bound, ctrl_cmd.div_step && (div_len_ff != '0) |-> (rem_ff < div_len_ff), "divider remainder not below divisor")

endmodule

`default_nettype wire

// ===== design/linear_adsr_envelope_top.sv =====
// ----------------------------------------------------------------------------
// linear_adsr_envelope_top
// Linear ADSR envelope generator with optional no-sustain mode.
//
// Requests (req_valid/req_ready) carry an action and a signed sample:
// tick, note on or note off. Note on and note off update the envelope in
// the cycle they are taken and give no response. A tick advances the stage
// counter, moves the stage, computes the Q1.16 level and scales the sample;
// it gives one response (rsp_valid/rsp_ready) with level, sample, stage.
// After a tick is taken the controller steps through advance, multiply,
// divide, level and scale; rsp_valid rises when scale loads the response.
// The level ramp needs one multiply step and a 17-step restoring divide,
// one quotient bit per cycle; a new request is taken in the cycle after
// the response is loaded. Note events can be taken every cycle while idle.
// The response sits in an output register: the next request is taken while
// it waits. If rsp_ready stays low, the following tick stalls in its last
// step until the register frees up. Reset (synchronous, active high) gives
// stage inactive, level zero, all lengths zero, sustain at full scale with
// sustain enabled. The csr port writes a register on any cycle with csr_wr_en
// high; the user must write only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_adsr_envelope_top
   import lae_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ACTION_BITS-1:0]        req_action,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [LEVEL_BITS-1:0]              rsp_level_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic [STAGE_BITS-1:0]              rsp_stage_out,
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   lae_cmd_type    ctrl_cmd;
   lae_status_type dp_status;

   // sequencer
   lae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .ctrl_cmd   (ctrl_cmd),
      .dp_status  (dp_status)
   );

   // envelope datapath
   lae_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl_cmd       (ctrl_cmd),
      .dp_status      (dp_status),
      .req_sample_in  (req_sample_in),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_level_out  (rsp_level_out),
      .rsp_sample_out (rsp_sample_out),
      .rsp_stage_out  (rsp_stage_out)
   );

endmodule

`default_nettype wire
